// File: rtl/ucs_pkg.sv
package ucs_pkg;

   // Event kinds on the request channel
   typedef enum logic [1:0] {
      MODE_BUS_RESET = 2'd0,
      MODE_SETUP     = 2'd1,
      MODE_POLL      = 2'd2,
      MODE_IN_DONE   = 2'd3
   } mode_type;

   // Commands on the response channel
   typedef enum logic [1:0] {
      ACT_WRITE     = 2'd0,
      ACT_SET_ADDR  = 2'd1,
      ACT_CONFIG_EP = 2'd2,
      ACT_REPORT    = 2'd3
   } action_type;

   // Write data sources
   typedef enum logic [1:0] {
      SRC_NONE       = 2'd0,
      SRC_DEVICE     = 2'd1,
      SRC_CONFIG     = 2'd2,
      SRC_HID_REPORT = 2'd3
   } source_type;

   typedef enum logic [1:0] {
      DEV_DEFAULT    = 2'd0,
      DEV_ADDRESSED  = 2'd1,
      DEV_CONFIGURED = 2'd2
   } dev_state_type;

   // Control stage, one-hot
   typedef enum logic [5:0] {
      STG_SETUP        = 6'b000001,
      STG_DATA_IN      = 6'b000010,
      STG_DATA_IN_IDLE = 6'b000100,
      STG_DATA_IN_ZERO = 6'b001000,
      STG_STATUS_OUT   = 6'b010000,
      STG_STATUS_IN    = 6'b100000
   } stage_type;

   localparam logic [2:0] STAGE_CODE_SETUP        = 3'd0;
   localparam logic [2:0] STAGE_CODE_DATA_IN      = 3'd1;
   localparam logic [2:0] STAGE_CODE_DATA_IN_IDLE = 3'd2;
   localparam logic [2:0] STAGE_CODE_DATA_IN_ZERO = 3'd3;
   localparam logic [2:0] STAGE_CODE_STATUS_OUT   = 3'd4;
   localparam logic [2:0] STAGE_CODE_STATUS_IN    = 3'd5;

   // Register indexes of the CSR port
   typedef enum logic [2:0] {
      REG_EP0_MAX_PACKET    = 3'd0,
      REG_REPORT_ENDPOINT   = 3'd1,
      REG_REPORT_EP_TYPE    = 3'd2,
      REG_REPORT_EP_MAX_PKT = 3'd3,
      REG_HID_REPORT_LENGTH = 3'd4
   } reg_index_type;

   // Setup decoding
   localparam logic [6:0] RTYPE_MASK       = 7'h7F;
   localparam logic [6:0] RTYPE_STD_DEVICE = 7'h00;
   localparam logic [6:0] RTYPE_STD_IFACE  = 7'h01;
   localparam logic [6:0] RTYPE_CLASS_IFACE = 7'h21;
   localparam logic [7:0] REQ_SET_ADDRESS  = 8'h05;
   localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
   localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
   localparam logic [7:0] REQ_SET_IDLE     = 8'h0A;
   localparam logic [7:0] DESC_DEVICE      = 8'h01;
   localparam logic [7:0] DESC_CONFIG      = 8'h02;
   localparam logic [7:0] DESC_HID_REPORT  = 8'h22;
   localparam logic [3:0] EP_CONTROL       = 4'h0;
   localparam logic [3:0] EP_MASK          = 4'h0F;

   // Configuration reset values
   localparam logic [6:0] EP0_MAX_PACKET_RESET  = 7'd64;
   localparam logic [3:0] REPORT_ENDPOINT_RESET = 4'd1;
   localparam logic [1:0] REPORT_EP_TYPE_RESET  = 2'd3;
   localparam logic [9:0] REPORT_EP_MAX_PKT_RESET = 10'd4;
   localparam logic [7:0] HID_REPORT_LENGTH_RESET = 8'd52;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] setup_value;
      logic [15:0] setup_length;
      logic [3:0]  endpoint_num;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  target_endpoint;
      source_type  source;
      logic [15:0] source_offset;
      logic [6:0]  packet_length;
      logic [6:0]  usb_address;
      logic [2:0]  stage_now;
      logic [1:0]  device_state_now;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] index;
      logic [9:0] data;
   } csr_type;

   typedef struct packed {
      logic [6:0] ep0_max_packet;
      logic [3:0] report_endpoint;
      logic [1:0] report_ep_type;
      logic [9:0] report_ep_max_packet;
      logic [7:0] hid_report_desc_length;
   } cfg_type;

   typedef struct packed {
      stage_type     stage;
      logic [15:0]   remaining_in;
      source_type    in_source;
      logic [15:0]   in_offset;
      dev_state_type dev_state;
      logic [7:0]    config_value;
   } state_type;

   function automatic logic [2:0] stage_code(stage_type s);
      logic [2:0] code;
      case (s)
         STG_SETUP:        code = STAGE_CODE_SETUP;
         STG_DATA_IN:      code = STAGE_CODE_DATA_IN;
         STG_DATA_IN_IDLE: code = STAGE_CODE_DATA_IN_IDLE;
         STG_DATA_IN_ZERO: code = STAGE_CODE_DATA_IN_ZERO;
         STG_STATUS_OUT:   code = STAGE_CODE_STATUS_OUT;
         STG_STATUS_IN:    code = STAGE_CODE_STATUS_IN;
         default:          code = STAGE_CODE_SETUP;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/ucs_chan_if.sv
// Valid/ready channel carrying one payload per transaction
interface ucs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/ucs_step.sv
// Next-state and command generation for one event
module ucs_step (
   input  ucs_pkg::req_type   item,
   input  ucs_pkg::state_type state,
   input  ucs_pkg::cfg_type   cfg,
   output ucs_pkg::state_type state_next,
   output ucs_pkg::rsp_type   res [2],
   output logic [1:0]         res_count
);

   logic [6:0]  rtype;
   logic [7:0]  dtype;
   logic [6:0]  pkt_len;
   logic [15:0] rem_after;
   logic        zlp_due;
   logic        rep_due;
   ucs_pkg::rsp_type blank;
   ucs_pkg::rsp_type zlp;
   ucs_pkg::rsp_type report;

   assign rtype = item.request_type[6:0] & ucs_pkg::RTYPE_MASK;
   assign dtype = item.setup_value[15:8];

   // Packet size for a data stage poll: the smaller of the bytes left and max packet
   assign pkt_len = (state.remaining_in < {9'd0, cfg.ep0_max_packet}) ?
                    state.remaining_in[6:0] : cfg.ep0_max_packet;
   assign rem_after = state.remaining_in - {9'd0, pkt_len};

   assign zlp_due = (state.remaining_in == 16'd0) &&
                    (state.stage == ucs_pkg::STG_DATA_IN_ZERO);
   assign rep_due = (item.endpoint_num == (cfg.report_endpoint & ucs_pkg::EP_MASK));

   always_comb begin
      blank = '0;
      blank.action = ucs_pkg::ACT_WRITE;
      blank.source = ucs_pkg::SRC_NONE;

      zlp = blank;
      zlp.target_endpoint = ucs_pkg::EP_CONTROL;

      report = blank;
      report.action = ucs_pkg::ACT_REPORT;
      report.target_endpoint = item.endpoint_num;
   end

   always_comb begin
      state_next = state;
      res[0] = blank;
      res[1] = blank;
      res_count = 2'd0;

      case (item.mode)
         ucs_pkg::MODE_BUS_RESET: begin
            // source and offset survive a bus reset
            state_next.remaining_in = '0;
            state_next.config_value = '0;
            state_next.dev_state = ucs_pkg::DEV_DEFAULT;
            state_next.stage = ucs_pkg::STG_SETUP;
            res[0].action = ucs_pkg::ACT_SET_ADDR;
            res_count = 2'd1;
         end

         ucs_pkg::MODE_SETUP: begin
            if (rtype == ucs_pkg::RTYPE_STD_DEVICE) begin
               if (item.request_code == ucs_pkg::REQ_GET_DESCRIPTOR) begin
                  if (dtype == ucs_pkg::DESC_DEVICE || dtype == ucs_pkg::DESC_CONFIG) begin
                     state_next.in_source = (dtype == ucs_pkg::DESC_DEVICE) ?
                                            ucs_pkg::SRC_DEVICE : ucs_pkg::SRC_CONFIG;
                     state_next.in_offset = '0;
                     state_next.remaining_in = item.setup_length;
                     state_next.stage = ucs_pkg::STG_DATA_IN;
                  end
               end else if (item.request_code == ucs_pkg::REQ_SET_ADDRESS) begin
                  res[0].action = ucs_pkg::ACT_SET_ADDR;
                  res[0].usb_address = item.setup_value[6:0];
                  res_count = 2'd1;
                  state_next.dev_state = ucs_pkg::DEV_ADDRESSED;
                  state_next.stage = ucs_pkg::STG_STATUS_IN;
               end else if (item.request_code == ucs_pkg::REQ_SET_CONFIGURATION) begin
                  state_next.config_value = item.setup_value[7:0];
                  res[0].action = ucs_pkg::ACT_CONFIG_EP;
                  res[0].target_endpoint = cfg.report_endpoint & ucs_pkg::EP_MASK;
                  res[1].target_endpoint = cfg.report_endpoint & ucs_pkg::EP_MASK;
                  res_count = 2'd2;
                  state_next.dev_state = ucs_pkg::DEV_CONFIGURED;
                  state_next.stage = ucs_pkg::STG_STATUS_IN;
               end
            end else if (rtype == ucs_pkg::RTYPE_CLASS_IFACE) begin
               if (item.request_code == ucs_pkg::REQ_SET_IDLE) begin
                  state_next.stage = ucs_pkg::STG_STATUS_IN;
               end
            end else if (rtype == ucs_pkg::RTYPE_STD_IFACE) begin
               // report descriptor length comes from the register, not wLength
               if (item.request_code == ucs_pkg::REQ_GET_DESCRIPTOR &&
                   dtype == ucs_pkg::DESC_HID_REPORT) begin
                  state_next.in_source = ucs_pkg::SRC_HID_REPORT;
                  state_next.in_offset = '0;
                  state_next.remaining_in = {8'd0, cfg.hid_report_desc_length};
                  state_next.stage = ucs_pkg::STG_DATA_IN;
               end
            end
         end

         ucs_pkg::MODE_POLL: begin
            case (state.stage)
               ucs_pkg::STG_DATA_IN: begin
                  res[0].target_endpoint = ucs_pkg::EP_CONTROL;
                  res[0].packet_length = pkt_len;
                  if (pkt_len != 7'd0) begin
                     res[0].source = state.in_source;
                     res[0].source_offset = state.in_offset;
                  end
                  res_count = 2'd1;
                  state_next.remaining_in = rem_after;
                  state_next.in_offset = state.in_offset + {9'd0, pkt_len};
                  if (rem_after != 16'd0) begin
                     state_next.stage = ucs_pkg::STG_DATA_IN_IDLE;
                  end else if (pkt_len == cfg.ep0_max_packet) begin
                     state_next.stage = ucs_pkg::STG_DATA_IN_ZERO;
                  end else begin
                     state_next.stage = ucs_pkg::STG_STATUS_OUT;
                  end
               end
               ucs_pkg::STG_STATUS_OUT: begin
                  state_next.stage = ucs_pkg::STG_SETUP;
               end
               ucs_pkg::STG_STATUS_IN: begin
                  res[0] = zlp;
                  res_count = 2'd1;
                  state_next.stage = ucs_pkg::STG_SETUP;
               end
               default: begin
                  state_next.stage = state.stage;
               end
            endcase
         end

         default: begin
            // IN complete: resume the data stage or close it with a ZLP, and report if it is the report endpoint
            if (state.remaining_in != 16'd0) begin
               state_next.stage = ucs_pkg::STG_DATA_IN;
            end else if (zlp_due) begin
               state_next.stage = ucs_pkg::STG_STATUS_OUT;
            end
            if (zlp_due) begin
               res[0] = zlp;
               res[1] = report;
               res_count = rep_due ? 2'd2 : 2'd1;
            end else begin
               res[0] = report;
               res_count = rep_due ? 2'd1 : 2'd0;
            end
         end
      endcase

      // status fields reflect the state after the event
      res[0].stage_now = ucs_pkg::stage_code(state_next.stage);
      res[1].stage_now = ucs_pkg::stage_code(state_next.stage);
      res[0].device_state_now = state_next.dev_state;
      res[1].device_state_now = state_next.dev_state;
      res[0].last = (res_count == 2'd1);
      res[1].last = 1'b1;
   end

endmodule

// File: rtl/usb_control_endpoint_sequencer_core.sv
// USB endpoint-zero control sequencer.
// A request passes the input register, then its commands the response slot pair.
// Throughput: one event per cycle while the response channel does not stall; an event
// with two commands holds the response slot pair until its second command is taken.
// Reset: synchronous, active high; clears stage, counters, device state and
// reloads the configuration registers with their defaults.
module usb_control_endpoint_sequencer_core (
   input logic  clock,
   input logic  reset,
   ucs_chan_if.sink   req_ch,
   ucs_chan_if.source rsp_ch,
   ucs_chan_if.sink   csr_ch
);

   logic               in_valid_ff, in_valid_in;
   ucs_pkg::req_type   in_item_ff, in_item_in;
   ucs_pkg::state_type state_ff, state_in;
   ucs_pkg::cfg_type   cfg_ff, cfg_in;
   ucs_pkg::rsp_type   slot_ff [2];
   ucs_pkg::rsp_type   slot_in [2];
   logic [1:0]         count_ff, count_in;

   ucs_pkg::state_type state_next;
   ucs_pkg::rsp_type   res [2];
   logic [1:0]         res_count;
   logic               rsp_pop;
   logic               process;

   ucs_step u_step (
      .item       (in_item_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_next),
      .res        (res),
      .res_count  (res_count)
   );

   // Handshakes
   assign rsp_pop = rsp_ch.valid && rsp_ch.ready;
   assign process = in_valid_ff &&
                    ((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_pop));
   assign req_ch.ready = !in_valid_ff || process;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = (count_ff != 2'd0);
   assign rsp_ch.payload = slot_ff[0];

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_item_in = req_ch.payload;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   // Event state
   assign state_in = process ? state_next : state_ff;

   // Response slot pair, head in slot 0
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in = count_ff;
      if (process) begin
         slot_in[0] = res[0];
         slot_in[1] = res[1];
         count_in = res_count;
      end else if (rsp_pop) begin
         slot_in[0] = slot_ff[1];
         count_in = count_ff - 2'd1;
      end
   end

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.payload.index)
            ucs_pkg::REG_EP0_MAX_PACKET:
               cfg_in.ep0_max_packet = csr_ch.payload.data[6:0];
            ucs_pkg::REG_REPORT_ENDPOINT:
               cfg_in.report_endpoint = csr_ch.payload.data[3:0];
            ucs_pkg::REG_REPORT_EP_TYPE:
               cfg_in.report_ep_type = csr_ch.payload.data[1:0];
            ucs_pkg::REG_REPORT_EP_MAX_PKT:
               cfg_in.report_ep_max_packet = csr_ch.payload.data[9:0];
            ucs_pkg::REG_HID_REPORT_LENGTH:
               cfg_in.hid_report_desc_length = csr_ch.payload.data[7:0];
            default:
               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff <= 2'd0;
         state_ff.stage <= ucs_pkg::STG_SETUP;
         state_ff.remaining_in <= '0;
         state_ff.in_source <= ucs_pkg::SRC_NONE;
         state_ff.in_offset <= '0;
         state_ff.dev_state <= ucs_pkg::DEV_DEFAULT;
         state_ff.config_value <= '0;
         cfg_ff.ep0_max_packet <= ucs_pkg::EP0_MAX_PACKET_RESET;
         cfg_ff.report_endpoint <= ucs_pkg::REPORT_ENDPOINT_RESET;
         cfg_ff.report_ep_type <= ucs_pkg::REPORT_EP_TYPE_RESET;
         cfg_ff.report_ep_max_packet <= ucs_pkg::REPORT_EP_MAX_PKT_RESET;
         cfg_ff.hid_report_desc_length <= ucs_pkg::HID_REPORT_LENGTH_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff <= count_in;
         state_ff <= state_in;
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/ucs_checker.sv
// Response channel checks on the core's ports
module ucs_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ucs_pkg::rsp_type rsp_payload
);

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // the second command of an event follows at once
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=> rsp_valid)
      else $error("second command of an event missing");

   // only set address carries an address
   a_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.action != ucs_pkg::ACT_SET_ADDR) |->
      (rsp_payload.usb_address == 7'd0))
      else $error("address on a non set address command");

   // a data packet always names its source
   a_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.action == ucs_pkg::ACT_WRITE) &&
      (rsp_payload.packet_length != 7'd0) |->
      (rsp_payload.source != ucs_pkg::SRC_NONE))
      else $error("data packet without a source");

endmodule

bind usb_control_endpoint_sequencer_core ucs_checker u_ucs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned WATCHDOG_LIMIT = 10000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned HOLD_OFF_CYCLES = 300;

   // Predicts the endpoint-zero commands and checks them in order
   class ep0_command_board;
      ucs_pkg::cfg_type       cfg;
      logic [2:0]             ctl_stage;
      logic [15:0]            in_remaining;
      ucs_pkg::source_type    in_src;
      logic [15:0]            in_off;
      ucs_pkg::dev_state_type dev_state;
      logic [7:0]             cfg_value;
      ucs_pkg::rsp_type       pending_commands[$];
      int unsigned            error_count;

      function new();
         cfg.ep0_max_packet         = ucs_pkg::EP0_MAX_PACKET_RESET;
         cfg.report_endpoint        = ucs_pkg::REPORT_ENDPOINT_RESET;
         cfg.report_ep_type         = ucs_pkg::REPORT_EP_TYPE_RESET;
         cfg.report_ep_max_packet   = ucs_pkg::REPORT_EP_MAX_PKT_RESET;
         cfg.hid_report_desc_length = ucs_pkg::HID_REPORT_LENGTH_RESET;
         ctl_stage    = ucs_pkg::STAGE_CODE_SETUP;
         in_remaining = '0;
         in_src       = ucs_pkg::SRC_NONE;
         in_off       = '0;
         dev_state    = ucs_pkg::DEV_DEFAULT;
         cfg_value    = '0;
         error_count  = 0;
      endfunction

      function void write_reg(ucs_pkg::csr_type w);
         case (w.index)
            ucs_pkg::REG_EP0_MAX_PACKET:    cfg.ep0_max_packet = w.data[6:0];
            ucs_pkg::REG_REPORT_ENDPOINT:   cfg.report_endpoint = w.data[3:0];
            ucs_pkg::REG_REPORT_EP_TYPE:    cfg.report_ep_type = w.data[1:0];
            ucs_pkg::REG_REPORT_EP_MAX_PKT: cfg.report_ep_max_packet = w.data;
            ucs_pkg::REG_HID_REPORT_LENGTH: cfg.hid_report_desc_length = w.data[7:0];
            default: ;
         endcase
      endfunction

      function ucs_pkg::rsp_type command(ucs_pkg::action_type act, logic [3:0] ep,
                                         ucs_pkg::source_type src, logic [15:0] off,
                                         logic [6:0] len, logic [6:0] addr);
         ucs_pkg::rsp_type c;
         c = '0;
         c.action          = act;
         c.target_endpoint = ep;
         c.source          = src;
         c.source_offset   = off;
         c.packet_length   = len;
         c.usb_address     = addr;
         return c;
      endfunction

      function void open_in(ucs_pkg::source_type src, logic [15:0] len);
         in_src       = src;
         in_off       = '0;
         in_remaining = len;
         ctl_stage    = ucs_pkg::STAGE_CODE_DATA_IN;
      endfunction

      // Works out the commands that one accepted event causes
      function void take_event(ucs_pkg::req_type ev);
         ucs_pkg::rsp_type batch[$];
         ucs_pkg::rsp_type c;
         logic [6:0]  rtype;
         logic [7:0]  dtype;
         logic [15:0] max_pkt;
         logic [15:0] chunk;
         logic [3:0]  rep_ep;
         rtype   = ev.request_type[6:0] & ucs_pkg::RTYPE_MASK;
         dtype   = ev.setup_value[15:8];
         max_pkt = {9'd0, cfg.ep0_max_packet};
         rep_ep  = cfg.report_endpoint & ucs_pkg::EP_MASK;
         case (ev.mode)
            ucs_pkg::MODE_BUS_RESET: begin
               // source and offset survive a bus reset
               in_remaining = '0;
               cfg_value    = '0;
               dev_state    = ucs_pkg::DEV_DEFAULT;
               ctl_stage    = ucs_pkg::STAGE_CODE_SETUP;
               batch.push_back(command(ucs_pkg::ACT_SET_ADDR, ucs_pkg::EP_CONTROL,
                                       ucs_pkg::SRC_NONE, '0, '0, '0));
            end
            ucs_pkg::MODE_SETUP: begin
               if (rtype == ucs_pkg::RTYPE_STD_DEVICE) begin
                  if (ev.request_code == ucs_pkg::REQ_GET_DESCRIPTOR) begin
                     if (dtype == ucs_pkg::DESC_DEVICE)
                        open_in(ucs_pkg::SRC_DEVICE, ev.setup_length);
                     else if (dtype == ucs_pkg::DESC_CONFIG)
                        open_in(ucs_pkg::SRC_CONFIG, ev.setup_length);
                  end else if (ev.request_code == ucs_pkg::REQ_SET_ADDRESS) begin
                     batch.push_back(command(ucs_pkg::ACT_SET_ADDR, ucs_pkg::EP_CONTROL,
                                             ucs_pkg::SRC_NONE, '0, '0,
                                             ev.setup_value[6:0]));
                     dev_state = ucs_pkg::DEV_ADDRESSED;
                     ctl_stage = ucs_pkg::STAGE_CODE_STATUS_IN;
                  end else if (ev.request_code == ucs_pkg::REQ_SET_CONFIGURATION) begin
                     cfg_value = ev.setup_value[7:0];
                     batch.push_back(command(ucs_pkg::ACT_CONFIG_EP, rep_ep,
                                             ucs_pkg::SRC_NONE, '0, '0, '0));
                     batch.push_back(command(ucs_pkg::ACT_WRITE, rep_ep,
                                             ucs_pkg::SRC_NONE, '0, '0, '0));
                     dev_state = ucs_pkg::DEV_CONFIGURED;
                     ctl_stage = ucs_pkg::STAGE_CODE_STATUS_IN;
                  end
               end else if (rtype == ucs_pkg::RTYPE_CLASS_IFACE) begin
                  if (ev.request_code == ucs_pkg::REQ_SET_IDLE)
                     ctl_stage = ucs_pkg::STAGE_CODE_STATUS_IN;
               end else if (rtype == ucs_pkg::RTYPE_STD_IFACE) begin
                  // report descriptor length comes from the register, not wLength
                  if (ev.request_code == ucs_pkg::REQ_GET_DESCRIPTOR &&
                      dtype == ucs_pkg::DESC_HID_REPORT)
                     open_in(ucs_pkg::SRC_HID_REPORT, {8'd0, cfg.hid_report_desc_length});
               end
            end
            ucs_pkg::MODE_POLL: begin
               if (ctl_stage == ucs_pkg::STAGE_CODE_DATA_IN) begin
                  chunk = (in_remaining < max_pkt) ? in_remaining : max_pkt;
                  batch.push_back(command(ucs_pkg::ACT_WRITE, ucs_pkg::EP_CONTROL,
                                          (chunk != 0) ? in_src : ucs_pkg::SRC_NONE,
                                          (chunk != 0) ? in_off : 16'd0,
                                          chunk[6:0], '0));
                  in_remaining = in_remaining - chunk;
                  in_off       = in_off + chunk;
                  if (in_remaining != 0) ctl_stage = ucs_pkg::STAGE_CODE_DATA_IN_IDLE;
                  else if (chunk == max_pkt) ctl_stage = ucs_pkg::STAGE_CODE_DATA_IN_ZERO;
                  else ctl_stage = ucs_pkg::STAGE_CODE_STATUS_OUT;
               end else if (ctl_stage == ucs_pkg::STAGE_CODE_STATUS_OUT) begin
                  ctl_stage = ucs_pkg::STAGE_CODE_SETUP;
               end else if (ctl_stage == ucs_pkg::STAGE_CODE_STATUS_IN) begin
                  batch.push_back(command(ucs_pkg::ACT_WRITE, ucs_pkg::EP_CONTROL,
                                          ucs_pkg::SRC_NONE, '0, '0, '0));
                  ctl_stage = ucs_pkg::STAGE_CODE_SETUP;
               end
            end
            default: begin
               // IN completion
               if (in_remaining != 0) begin
                  ctl_stage = ucs_pkg::STAGE_CODE_DATA_IN;
               end else if (ctl_stage == ucs_pkg::STAGE_CODE_DATA_IN_ZERO) begin
                  batch.push_back(command(ucs_pkg::ACT_WRITE, ucs_pkg::EP_CONTROL,
                                          ucs_pkg::SRC_NONE, '0, '0, '0));
                  ctl_stage = ucs_pkg::STAGE_CODE_STATUS_OUT;
               end
               if (ev.endpoint_num == rep_ep)
                  batch.push_back(command(ucs_pkg::ACT_REPORT, rep_ep,
                                          ucs_pkg::SRC_NONE, '0, '0, '0));
            end
         endcase
         foreach (batch[k]) begin
            c = batch[k];
            c.stage_now        = ctl_stage;
            c.device_state_now = dev_state;
            c.last             = (k == batch.size() - 1);
            pending_commands.push_back(c);
         end
      endfunction

      function string describe(ucs_pkg::rsp_type c);
         return $sformatf({"action=%0d ep=%0d source=%0d offset=%0d length=%0d ",
                           "address=%0d stage=%0d state=%0d last=%0d"},
                          c.action, c.target_endpoint, c.source, c.source_offset,
                          c.packet_length, c.usb_address, c.stage_now,
                          c.device_state_now, c.last);
      endfunction

      function void flag(string msg);
         error_count++;
         if (error_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
      endfunction

      // Compares one accepted command with the oldest prediction
      function void check_command(ucs_pkg::rsp_type got);
         ucs_pkg::rsp_type want;
         string   bad;
         if (pending_commands.size() == 0) begin
            flag($sformatf("unexpected command: %s", describe(got)));
            return;
         end
         want = pending_commands.pop_front();
         bad  = "";
         if (got.action !== want.action) bad = {bad, " action"};
         if (got.target_endpoint !== want.target_endpoint) bad = {bad, " target_endpoint"};
         if (got.source !== want.source) bad = {bad, " source"};
         if (got.source_offset !== want.source_offset) bad = {bad, " source_offset"};
         if (got.packet_length !== want.packet_length) bad = {bad, " packet_length"};
         if (got.usb_address !== want.usb_address) bad = {bad, " usb_address"};
         if (got.stage_now !== want.stage_now) bad = {bad, " stage_now"};
         if (got.device_state_now !== want.device_state_now) bad = {bad, " device_state_now"};
         if (got.last !== want.last) bad = {bad, " last"};
         if (bad != "")
            flag($sformatf("command mismatch on%s\n  expected %s\n  actual   %s",
                           bad, describe(want), describe(got)));
      endfunction

      function void close_out();
         if (pending_commands.size() != 0)
            flag($sformatf("%0d predicted commands never arrived", pending_commands.size()));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ucs_chan_if #(.payload_type(ucs_pkg::req_type)) req_ch ();
   ucs_chan_if #(.payload_type(ucs_pkg::rsp_type)) rsp_ch ();
   ucs_chan_if #(.payload_type(ucs_pkg::csr_type)) csr_ch ();

   ep0_command_board cmd_board = new();

   int unsigned tx_idle_pct = 32;
   int unsigned rx_idle_pct = 59;
   int unsigned rsp_hold_cycles = 0;
   int unsigned events_sent = 0;
   int unsigned noise_sent = 0;
   int unsigned quiet_cycles = 0;

   usb_control_endpoint_sequencer_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // Command receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Transaction monitor on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) cmd_board.check_command(rsp_ch.payload);
         if (req_ch.valid && req_ch.ready) cmd_board.take_event(req_ch.payload);
         if (csr_ch.valid && csr_ch.ready) cmd_board.write_reg(csr_ch.payload);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   // Watchdog
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic ucs_pkg::req_type event_of(ucs_pkg::mode_type m, logic [7:0] rtype,
                                                 logic [7:0] code, logic [15:0] value,
                                                 logic [15:0] len, logic [3:0] ep);
      ucs_pkg::req_type r;
      r.mode         = m;
      r.request_type = rtype;
      r.request_code = code;
      r.setup_value  = value;
      r.setup_length = len;
      r.endpoint_num = ep;
      return r;
   endfunction

   function automatic ucs_pkg::req_type random_event(ucs_pkg::mode_type m);
      return event_of(m, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      4'($urandom));
   endfunction

   // Mostly short transfers, some on packet boundaries, a few huge
   function automatic logic [15:0] transfer_length();
      case ($urandom_range(9))
         6, 7:    return 16'(cmd_board.cfg.ep0_max_packet * $urandom_range(1, 3));
         8:       return 16'hFFFF;
         9:       return 16'($urandom);
         default: return 16'($urandom_range(150));
      endcase
   endfunction

   task automatic drive_event(ucs_pkg::req_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      events_sent++;
   endtask

   // Wait until every predicted command is in and the block has gone quiet
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (cmd_board.pending_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(ucs_pkg::reg_index_type idx, logic [9:0] value);
      ucs_pkg::csr_type w;
      w.index = idx;
      w.data  = value;
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= w;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic apply_settings(logic [6:0] ep0_pkt, logic [3:0] rep_ep,
                                 logic [1:0] ep_kind, logic [9:0] rep_pkt,
                                 logic [7:0] hid_len);
      drain();
      write_register(ucs_pkg::REG_EP0_MAX_PACKET, {3'd0, ep0_pkt});
      write_register(ucs_pkg::REG_REPORT_ENDPOINT, {6'd0, rep_ep});
      write_register(ucs_pkg::REG_REPORT_EP_TYPE, {8'd0, ep_kind});
      write_register(ucs_pkg::REG_REPORT_EP_MAX_PKT, rep_pkt);
      write_register(ucs_pkg::REG_HID_REPORT_LENGTH, {2'd0, hid_len});
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_directed();
      ucs_pkg::req_type poll_ev;
      poll_ev = event_of(ucs_pkg::MODE_POLL, '0, '0, '0, '0, '0);
      drive_event(event_of(ucs_pkg::MODE_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                           4'hF));
      // poll with nothing in flight
      drive_event(poll_ev);
      // short device descriptor
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h80, ucs_pkg::REQ_GET_DESCRIPTOR,
                           {ucs_pkg::DESC_DEVICE, 8'h00}, 16'd18, 4'h0));
      drive_event(poll_ev);
      drive_event(poll_ev);
      // two full packets then a zero-length packet, report endpoint completes too
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h00, ucs_pkg::REQ_GET_DESCRIPTOR,
                           {ucs_pkg::DESC_CONFIG, 8'h00}, 16'd128, 4'h0));
      drive_event(poll_ev);
      drive_event(event_of(ucs_pkg::MODE_IN_DONE, '0, '0, '0, '0, ucs_pkg::EP_CONTROL));
      drive_event(poll_ev);
      drive_event(event_of(ucs_pkg::MODE_IN_DONE, '0, '0, '0, '0,
                           ucs_pkg::REPORT_ENDPOINT_RESET));
      drive_event(poll_ev);
      // report descriptor ignores wLength
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h81, ucs_pkg::REQ_GET_DESCRIPTOR,
                           {ucs_pkg::DESC_HID_REPORT, 8'h00}, 16'hFFFF, 4'h0));
      drive_event(poll_ev);
      drive_event(poll_ev);
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h00, ucs_pkg::REQ_SET_ADDRESS, 16'hFFFF,
                           16'h0000, 4'h0));
      drive_event(poll_ev);
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h00, ucs_pkg::REQ_SET_CONFIGURATION,
                           16'h00FF, 16'h0, 4'h0));
      drive_event(poll_ev);
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h21, ucs_pkg::REQ_SET_IDLE, 16'h0000,
                           16'h0000, 4'h0));
      drive_event(poll_ev);
      // unknown request type, all-ones setup, foreign endpoint completion
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h40, ucs_pkg::REQ_GET_DESCRIPTOR,
                           {ucs_pkg::DESC_DEVICE, 8'h00}, 16'd18, 4'h0));
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
      drive_event(event_of(ucs_pkg::MODE_IN_DONE, '0, '0, '0, '0, 4'hF));
      // zero-length request, then a huge one cut short by a bus reset
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h80, ucs_pkg::REQ_GET_DESCRIPTOR,
                           {ucs_pkg::DESC_DEVICE, 8'h00}, 16'd0, 4'h0));
      drive_event(poll_ev);
      drive_event(event_of(ucs_pkg::MODE_SETUP, 8'h80, ucs_pkg::REQ_GET_DESCRIPTOR,
                           {ucs_pkg::DESC_DEVICE, 8'h00}, 16'hFFFF, 4'h0));
      drive_event(poll_ev);
      drive_event(event_of(ucs_pkg::MODE_BUS_RESET, '0, '0, '0, '0, '0));
   endtask

   // GET_DESCRIPTOR followed by rounds of polls and IN completions
   task automatic run_descriptor_transfer();
      ucs_pkg::req_type r;
      int unsigned      kind;
      kind = $urandom_range(2);
      r = random_event(ucs_pkg::MODE_SETUP);
      r.request_code = ucs_pkg::REQ_GET_DESCRIPTOR;
      r.request_type = {1'($urandom_range(1)),
                        (kind == 2) ? ucs_pkg::RTYPE_STD_IFACE : ucs_pkg::RTYPE_STD_DEVICE};
      r.setup_value  = {(kind == 0) ? ucs_pkg::DESC_DEVICE :
                        (kind == 1) ? ucs_pkg::DESC_CONFIG : ucs_pkg::DESC_HID_REPORT,
                        8'($urandom)};
      r.setup_length = transfer_length();
      drive_event(r);
      repeat ($urandom_range(1, 6)) begin
         drive_event(random_event(ucs_pkg::MODE_POLL));
         r = random_event(ucs_pkg::MODE_IN_DONE);
         if ($urandom_range(3) != 0) r.endpoint_num = ucs_pkg::EP_CONTROL;
         drive_event(r);
      end
      drive_event(random_event(ucs_pkg::MODE_POLL));
      drive_event(random_event(ucs_pkg::MODE_POLL));
   endtask

   task automatic run_random(int unsigned target);
      int unsigned      start;
      int unsigned      pick;
      ucs_pkg::req_type r;
      start = events_sent - noise_sent;
      while (events_sent - noise_sent - start < target) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            run_descriptor_transfer();
         end else if (pick < 62) begin
            r = random_event(ucs_pkg::MODE_SETUP);
            case ($urandom_range(2))
               0: begin
                  r.request_type = {1'($urandom_range(1)), ucs_pkg::RTYPE_STD_DEVICE};
                  r.request_code = ucs_pkg::REQ_SET_ADDRESS;
               end
               1: begin
                  r.request_type = {1'($urandom_range(1)), ucs_pkg::RTYPE_STD_DEVICE};
                  r.request_code = ucs_pkg::REQ_SET_CONFIGURATION;
               end
               default: begin
                  r.request_type = {1'($urandom_range(1)), ucs_pkg::RTYPE_CLASS_IFACE};
                  r.request_code = ucs_pkg::REQ_SET_IDLE;
               end
            endcase
            drive_event(r);
            drive_event(random_event(ucs_pkg::MODE_POLL));
         end else if (pick < 70) begin
            drive_event(random_event(ucs_pkg::MODE_BUS_RESET));
         end else if (pick < 80) begin
            r = random_event(ucs_pkg::MODE_IN_DONE);
            if ($urandom_range(1) != 0) r.endpoint_num = cmd_board.cfg.report_endpoint;
            drive_event(r);
         end else begin
            // noise: any event kind with random fields
            noise_sent++;
            drive_event(random_event(ucs_pkg::mode_type'($urandom_range(3))));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles often, receiver idles more
      run_directed();
      apply_settings(7'd8, 4'd15, 2'd0, 10'd0, 8'd0);
      run_random(170);

      // roles swapped; long receiver hold-off, then a full pause
      tx_idle_pct = 59;
      rx_idle_pct = 32;
      apply_settings(7'd64, 4'd1, 2'd3, 10'd1023, 8'd255);
      run_random(40);
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      run_random(60);
      drain();
      run_random(70);

      // no idling from here on
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      apply_settings(7'd127, 4'($urandom_range(15)), 2'($urandom_range(3)),
                     10'($urandom_range(1023)), 8'($urandom_range(255)));
      run_random(120);
      // zero packet size: transfers never progress
      apply_settings(7'd0, 4'd0, 2'd3, 10'd4, 8'd52);
      run_random(40);

      drain();
      cmd_board.close_out();
      if (cmd_board.error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
